// ----- sv/b64e_pkg.sv -----
// Shared types, constants and the alphabet lookup of the Base64 stream encoder.
package b64e_pkg;

  localparam logic [7:0] PadChar = 8'h3D;
  localparam int unsigned MaxChars = 4;
  localparam int unsigned CharIdxW = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       run_end;
    logic       message_end;
  } out_item_t;

  // Everything one input byte produces: up to four ready ASCII characters.
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CharIdxW-1:0]      last_idx;
    logic                     final_job;
  } job_t;

  // Maps a six-bit value onto the standard Base64 alphabet.
  function automatic logic [7:0] enc_char(input logic [5:0] six);
    logic [7:0] v;
    logic [7:0] ch;
    v = {2'b00, six};
    if (six < 6'd26) begin
      ch = 8'h41 + v;
    end else if (six < 6'd52) begin
      ch = 8'h61 + v - 8'd26;
    end else if (six < 6'd62) begin
      ch = 8'h30 + v - 8'd52;
    end else if (six == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

// ----- sv/b64e_front.sv -----
// Front end: accepts bytes, tracks the group position and builds character jobs.
module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64e_pkg::in_item_t in_item_i,
  input  logic              job_full_i,
  output logic              job_wr_o,
  output b64e_pkg::job_t    job_o
);
  import b64e_pkg::*;

  localparam logic [1:0] PhaseZero = 2'd0;
  localparam logic [1:0] PhaseOne  = 2'd1;
  localparam logic [1:0] PhaseTwo  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic [7:0] b;
  logic       fin;
  logic       accept;

  assign b        = in_item_i.data_byte;
  assign fin      = in_item_i.final_byte;
  assign accept   = push_i & ~job_full_i;
  assign job_wr_o = accept;

  always_comb begin
    job_o.chars     = '0;
    job_o.last_idx  = '0;
    job_o.final_job = fin;
    phase_d         = phase_q;
    left_d          = left_q;
    unique case (phase_q)
      PhaseOne: begin
        job_o.chars[0] = enc_char({left_q[1:0], b[7:4]});
        if (fin) begin
          job_o.chars[1] = enc_char({b[3:0], 2'b00});
          job_o.chars[2] = PadChar;
          job_o.last_idx = 2'd2;
        end
        phase_d = PhaseTwo;
        left_d  = b[3:0];
      end
      PhaseTwo: begin
        job_o.chars[0] = enc_char({left_q, b[7:6]});
        job_o.chars[1] = enc_char(b[5:0]);
        job_o.last_idx = 2'd1;
        phase_d        = PhaseZero;
        left_d         = '0;
      end
      default: begin
        // The unused phase code behaves like the start of a group.
        job_o.chars[0] = enc_char(b[7:2]);
        if (fin) begin
          job_o.chars[1] = enc_char({b[1:0], 4'b0000});
          job_o.chars[2] = PadChar;
          job_o.chars[3] = PadChar;
          job_o.last_idx = 2'd3;
        end
        phase_d = PhaseOne;
        left_d  = {2'b00, b[1:0]};
      end
    endcase
    if (fin) begin
      phase_d = PhaseZero;
      left_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseZero;
      left_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3) else $error("group phase left its legal range");

  a_final_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fin |=> phase_q == PhaseZero && left_q == '0)
    else $error("a final byte did not return the encoder to the group start");

endmodule

// ----- sv/b64e_fifo.sv -----
// Short job queue between the front end and the character sequencer.
module b64e_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  b64e_pkg::job_t wr_job_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           valid_o,
  output b64e_pkg::job_t rd_job_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o   = (cnt_q == FullCnt);
  assign valid_o  = (cnt_q != '0);
  assign rd_job_o = slots_q[rd_ptr_q];
  assign do_wr    = wr_i & ~full_o;
  assign do_rd    = rd_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("job queue count exceeds its depth");

endmodule

// ----- sv/b64e_back.sv -----
// Back end: walks through one job and hands out one character per transfer.
module b64e_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  b64e_pkg::job_t     job_i,
  output logic               job_rd_o,
  input  logic               pop_i,
  output logic               empty_o,
  output b64e_pkg::out_item_t out_item_o
);
  import b64e_pkg::*;

  job_t                cur_q;
  logic                busy_q;
  logic [CharIdxW-1:0] idx_q;
  logic                at_last, take, load;

  assign at_last = (idx_q == cur_q.last_idx);
  assign take    = pop_i & busy_q;
  // A new job moves in when the register is idle or its last character leaves.
  assign load    = job_valid_i & (~busy_q | (take & at_last));
  assign job_rd_o = load;

  assign empty_o                = ~busy_q;
  assign out_item_o.ascii_char  = cur_q.chars[idx_q];
  assign out_item_o.run_end     = at_last;
  assign out_item_o.message_end = at_last & cur_q.final_job;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (take) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  a_msg_end_is_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && out_item_o.message_end |-> out_item_o.run_end)
    else $error("message end flagged on a character that does not end its run");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !at_last |=> !empty_o && idx_q == $past(idx_q) + 1'b1)
    else $error("a character run was cut short");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !busy_q || (take && at_last))
    else $error("a job overwrote one that was still being delivered");

endmodule

// ----- sv/base64_stream_encoder_unit.sv -----
// Top level of the streaming Base64 encoder: front end, job queue and back end.
//
//  Channel   Handshake            Payload      Transfer when
//  input     push / full          in_item_i    push && !full
//  result    pop / empty          out_item_o   pop && !empty
//
// A byte is turned into a job of one to four characters at once.
// The back end hands out one character per cycle while pop is held; a byte makes
// one or two characters within a message, up to four on the final byte.
// The job queue of JobDepth entries lets the input keep flowing while results stall.
// Reset clears the group position, the queue and the output; no clearing pass is needed.
module base64_stream_encoder_unit #(
  parameter int unsigned JobDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  b64e_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output b64e_pkg::out_item_t out_item_o
);
  import b64e_pkg::*;

  logic job_wr, job_full, job_rd, job_valid;
  job_t wr_job, rd_job;

  assign full = job_full;

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .job_full_i (job_full),
    .job_wr_o   (job_wr),
    .job_o      (wr_job)
  );

  b64e_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (job_wr),
    .wr_job_i (wr_job),
    .full_o   (job_full),
    .rd_i     (job_rd),
    .valid_o  (job_valid),
    .rd_job_o (rd_job)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (rd_job),
    .job_rd_o    (job_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- tb/base64_stream_encoder_unit_chk.sv -----
`timescale 1ns / 1ps
// Checker for the Base64 stream encoder: predicts each character and compares transfers.
module base64_stream_encoder_unit_chk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  b64e_pkg::in_item_t  in_item_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  b64e_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);
  import b64e_pkg::*;

  localparam logic [511:0] Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [7:0] PadSym = "=";

  logic [1:0] grp_phase;
  logic [3:0] carry_bits;
  out_item_t  char_queue[$];
  out_item_t  want;
  int         fails;
  int         checked;

  // The first alphabet character sits in the top byte of the packed string.
  function automatic logic [7:0] b64_symbol(input logic [5:0] six);
    return Alphabet[(63 - int'(six)) * 8 +: 8];
  endfunction

  function automatic out_item_t mk_char(input logic [7:0] ch);
    out_item_t c;
    c = '0;
    c.ascii_char = ch;
    return c;
  endfunction

  task automatic encode_byte(input in_item_t item);
    out_item_t  tail;
    logic [7:0] b;
    b = item.data_byte;
    case (grp_phase)
      2'd1: begin
        char_queue.push_back(mk_char(b64_symbol({carry_bits[1:0], b[7:4]})));
        carry_bits = b[3:0];
        grp_phase  = 2'd2;
      end
      2'd2: begin
        char_queue.push_back(mk_char(b64_symbol({carry_bits, b[7:6]})));
        char_queue.push_back(mk_char(b64_symbol(b[5:0])));
        carry_bits = 4'd0;
        grp_phase  = 2'd0;
      end
      default: begin
        char_queue.push_back(mk_char(b64_symbol(b[7:2])));
        carry_bits = {2'b00, b[1:0]};
        grp_phase  = 2'd1;
      end
    endcase
    // A final byte flushes the partial group with zero fill and padding.
    if (item.final_byte) begin
      if (grp_phase == 2'd1) begin
        char_queue.push_back(mk_char(b64_symbol({carry_bits[1:0], 4'b0000})));
        char_queue.push_back(mk_char(PadSym));
        char_queue.push_back(mk_char(PadSym));
      end else if (grp_phase == 2'd2) begin
        char_queue.push_back(mk_char(b64_symbol({carry_bits, 2'b00})));
        char_queue.push_back(mk_char(PadSym));
      end
      grp_phase  = 2'd0;
      carry_bits = 4'd0;
    end
    tail = char_queue.pop_back();
    tail.run_end     = 1'b1;
    tail.message_end = item.final_byte;
    char_queue.push_back(tail);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_phase  = 2'd0;
      carry_bits = 4'd0;
      char_queue.delete();
      fails      = 0;
      checked    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (push_i && !full_i) begin
        encode_byte(in_item_i);
      end
      if (pop_i && !empty_i) begin
        if (char_queue.size() == 0) begin
          $display("%0t: unexpected character: expected none, got char %02h %s %0b %s %0b",
                   $time, out_item_i.ascii_char, "run_end", out_item_i.run_end,
                   "message_end", out_item_i.message_end);
          fails++;
        end else begin
          want = char_queue.pop_front();
          checked++;
          if (want.ascii_char !== out_item_i.ascii_char ||
              want.run_end !== out_item_i.run_end ||
              want.message_end !== out_item_i.message_end) begin
            $display("%0t: mismatch: expected char %02h run_end %0b message_end %0b,",
                     $time, want.ascii_char, want.run_end, want.message_end);
            $display("    got char %02h run_end %0b message_end %0b",
                     out_item_i.ascii_char, out_item_i.run_end, out_item_i.message_end);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= char_queue.size();
      checked_o    <= checked;
    end
  end

endmodule

// ----- tb/base64_stream_encoder_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the Base64 stream encoder: clock, reset, byte stimulus and verdict.
module base64_stream_encoder_unit_tb;
  import b64e_pkg::*;

  localparam int NumDirected = 22;
  localparam int RandomItems = 148;

  // Directed messages: single bytes with one leftover, two leftovers, full final groups,
  // the '+' and '/' characters, and longer messages that end with one or two leftover bytes.
  localparam logic [NumDirected*8-1:0] DirBytes = {
    8'h00,
    8'hFF,
    8'hFF, 8'hFF,
    8'h00, 8'h00, 8'h00,
    8'hFB, 8'hEF, 8'hBE,
    8'hFF, 8'hFF, 8'hFF,
    8'h4D, 8'h61, 8'h6E, 8'h80,
    8'h01, 8'h02, 8'h7F, 8'hFE, 8'h55
  };
  localparam logic [NumDirected-1:0] DirLast = 22'b1_0000_1000_1001_0010_0101_1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        checked;
  int        bytes_sent = 0;
  int        messages_sent = 0;
  int        burst_left = 0;
  int        rx_mode = 0;
  int        rx_timer = 0;
  int        rx_stall = 0;

  always #5 clk = ~clk;

  base64_stream_encoder_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  base64_stream_encoder_unit_chk chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_i       (full),
    .in_item_i    (in_item),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Receiver: switches between steady popping, random stalls, sparse pops and long stalls.
  always @(posedge clk) begin
    if (rx_timer == 0) begin
      rx_mode  <= $urandom_range(0, 3);
      rx_timer <= $urandom_range(16, 80);
    end else begin
      rx_timer <= rx_timer - 1;
    end
    case (rx_mode)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(0, 1));
      2: pop <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_stall == 0) begin
          pop      <= 1'b1;
          rx_stall <= $urandom_range(0, 8);
        end else begin
          pop      <= 1'b0;
          rx_stall <= rx_stall - 1;
        end
      end
    endcase
  end

  // Sender: bursts of random length separated by random idle gaps.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_item_t item;
    int       gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item.data_byte  = b;
    item.final_byte = fin;
    push    <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (full);
    bytes_sent++;
    if (fin) messages_sent++;
  endtask

  initial begin
    #2_000_000;
    $display("Timeout at %0t with %0d characters still outstanding", $time, pending);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int         len;
    int         r;
    logic [7:0] b;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDirected; i++) begin
      send_byte(DirBytes[(NumDirected - 1 - i) * 8 +: 8], DirLast[i]);
    end

    // Mostly short messages so that every flush case recurs, with some long ones.
    while (bytes_sent < NumDirected + RandomItems) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        len = $urandom_range(1, 3);
      end else if (r < 9) begin
        len = $urandom_range(4, 12);
      end else begin
        len = $urandom_range(13, 40);
      end
      if (len > NumDirected + RandomItems - bytes_sent) begin
        len = NumDirected + RandomItems - bytes_sent;
      end
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 7);
        if (r == 0) begin
          b = 8'h00;
        end else if (r == 1) begin
          b = 8'hFF;
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        send_byte(b, k == len - 1);
      end
    end
    push <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d bytes in %0d messages, directed edge cases then random lengths;",
             bytes_sent, messages_sent);
    $display("%0d characters compared, %0d failures.", checked, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
